// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define MBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property that also holds during reset
`define MBD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/mbd_pkg.sv =====
`default_nettype none

package mbd_pkg;

    // item field widths
    localparam int TQ_W       = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int GAIN_W     = 24;
    localparam int ACC_W      = 32;

    // internal datapath widths
    localparam int SUM_W      = 18;  // sum of four torques
    localparam int FORCE_W    = 35;  // torque sum times inverse radius
    localparam int LR_W       = 32;  // lever arm times inverse radius
    localparam int PROD_W     = 51;  // torque sum times LR
    localparam int XY_W       = 33;  // cordic vector
    localparam int Z_W        = 33;  // cordic angle, q30
    localparam int TRIG_W     = 18;  // cos and sin, q16
    localparam int WSUM_W     = 54;  // force times trig, q16.32
    localparam int MAG_W      = 42;  // magnitude fed to the scaler
    localparam int MAG_SPLIT  = 21;  // low half of the magnitude split

    localparam int TRIG_SHIFT = 14;
    localparam int TZ_SHIFT   = 8;
    localparam int Q_SHIFT    = 16;
    localparam int ATAN_LEN   = 24;

    localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVER_ARM        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_INERTIA      = 2'd3;

    localparam logic [15:0]         RST_INV_WHEEL_RADIUS = 16'd256;
    localparam logic [15:0]         RST_LEVER_ARM        = 16'd256;
    localparam logic [GAIN_W-1:0]   RST_INV_MASS         = 24'd65536;
    localparam logic [GAIN_W-1:0]   RST_INV_INERTIA      = 24'd65536;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sh026DD3B6A;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [Z_W-1:0]  PI_Q30      = 33'sd3373259426;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

    // arctangent of 2^-i in q30, truncated
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic signed [TQ_W-1:0] vx;
        logic signed [TQ_W-1:0] vy;
        logic signed [TQ_W-1:0] wz;
    } vel_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } rot_t;

    // values that ride along the cordic chain
    typedef struct packed {
        logic signed [FORCE_W-1:0] bfx;
        logic signed [FORCE_W-1:0] bfy;
        logic [LR_W-1:0]           lr;
        logic signed [SUM_W-1:0]   st;
        logic                      flip;
        vel_t                      vel;
    } side_t;

    typedef struct packed {
        vel_t                    vel;
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] az;
    } res_t;

endpackage

`default_nettype wire

// ===== src/mbd_cordic_cell.sv =====
`default_nettype none

// one rotation-mode cordic iteration with a register behind it
module mbd_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          ce,
    input  wire logic          in_valid,
    input  wire mbd_pkg::rot_t in_rot,
    input  wire mbd_pkg::side_t in_side,
    output logic               out_valid,
    output mbd_pkg::rot_t      out_rot,
    output mbd_pkg::side_t     out_side
);
    import mbd_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_TAB[STAGE]);

    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;
    rot_t                   rot_next;
    logic                   valid_reg;
    rot_t                   rot_reg;
    side_t                  side_reg;

    always_comb begin
        x_sh = in_rot.x >>> STAGE;
        y_sh = in_rot.y >>> STAGE;
        if (!in_rot.z[Z_W-1]) begin
            rot_next.x = in_rot.x - y_sh;
            rot_next.y = in_rot.y + x_sh;
            rot_next.z = in_rot.z - ATAN_STEP;
        end else begin
            rot_next.x = in_rot.x + y_sh;
            rot_next.y = in_rot.y - x_sh;
            rot_next.z = in_rot.z + ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rot_reg  <= rot_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rot   = rot_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// ===== src/mbd_scale.sv =====
`default_nettype none

// sign-magnitude times unsigned gain, truncated toward zero to q16, saturated
module mbd_scale (
    input  wire logic                              aclk,
    input  wire logic                              ce,
    input  wire logic                              sign_in,
    input  wire logic [mbd_pkg::MAG_W-1:0]         mag_in,
    input  wire logic [mbd_pkg::GAIN_W-1:0]        gain,
    output logic signed [mbd_pkg::ACC_W-1:0]       acc_out
);
    import mbd_pkg::*;

    localparam int PART_W = MAG_W - MAG_SPLIT + GAIN_W;
    localparam int LO_W   = MAG_SPLIT + GAIN_W;
    localparam int SCL_W  = PART_W + MAG_SPLIT - Q_SHIFT + 1;

    localparam logic [SCL_W-1:0] POS_LIMIT = SCL_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [SCL_W-1:0] NEG_LIMIT = SCL_W'(64'h0000_0000_8000_0000);

    logic                    a_sign_reg;
    logic [PART_W-1:0]       a_hi_reg;
    logic [LO_W-1:0]         a_lo_reg;
    logic                    b_sign_reg;
    logic [SCL_W-1:0]        b_mag_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic [SCL_W-1:0]        mag_next;

    // partial products over the two halves of the magnitude
    always_ff @(posedge aclk) begin
        if (ce) begin
            a_sign_reg <= sign_in;
            a_hi_reg   <= PART_W'(mag_in[MAG_W-1:MAG_SPLIT]) * PART_W'(gain);
            a_lo_reg   <= LO_W'(mag_in[MAG_SPLIT-1:0]) * LO_W'(gain);
        end
    end

    assign mag_next = (SCL_W'(a_hi_reg) << (MAG_SPLIT - Q_SHIFT))
                    + SCL_W'(a_lo_reg >> Q_SHIFT);

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_sign_reg <= a_sign_reg;
            b_mag_reg  <= mag_next;
        end
    end

    always_comb begin
        if (!b_sign_reg) begin
            acc_next = (b_mag_reg > POS_LIMIT) ? ACC_MAX : $signed(b_mag_reg[ACC_W-1:0]);
        end else begin
            acc_next = (b_mag_reg > NEG_LIMIT) ? ACC_MIN : -$signed(b_mag_reg[ACC_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

`default_nettype wire

// ===== src/mecanum_body_dynamics_derivative.sv =====
`default_nettype none

// mecanum drive rigid body derivative: takes four wheel torques, the heading and
// the three velocities, and returns dx, dy, dheading (the velocities passed on)
// plus world x/y acceleration and yaw acceleration in saturated q16.16. one item
// enters per clock while results are taken; between input and result lie the
// input register, the chain of cordic cells that produces sine and cosine, four
// multiply/add stages, the three-stage gain scaler and the output register. a
// full output stalls the whole pipeline only once the skid register behind the
// output is occupied, so s_ready never depends combinationally on m_ready. the
// four registers (inverse wheel radius, lever arm, inverse mass, inverse
// inertia) are written through the cfg port; the user must write them only while
// no item is in flight, as the block itself does not enforce it; index 0..3 in
// that order, data in the low bits. there is no memory and no clearing pass
// after reset.
module mecanum_body_dynamics_derivative #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // configuration writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [23:0]          cfg_wdata,

    // input items
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [15:0]   s_torque_front_left,
    input  wire logic signed [15:0]   s_torque_front_right,
    input  wire logic signed [15:0]   s_torque_back_left,
    input  wire logic signed [15:0]   s_torque_back_right,
    input  wire logic signed [15:0]   s_heading,
    input  wire logic signed [15:0]   s_vel_x,
    input  wire logic signed [15:0]   s_vel_y,
    input  wire logic signed [15:0]   s_yaw_rate,

    // result items
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [15:0]        m_dx,
    output logic signed [15:0]        m_dy,
    output logic signed [15:0]        m_dheading,
    output logic signed [31:0]        m_accel_x,
    output logic signed [31:0]        m_accel_y,
    output logic signed [31:0]        m_yaw_accel
);
    import mbd_pkg::*;

    // stages after the cordic chain: trig/lr, products, sums, magnitude, scaler x3
    localparam int POST_STAGES = 7;
    localparam int LAST        = POST_STAGES - 1;
    localparam logic signed [XY_W-1:0] TRUNC_BIAS = XY_W'((1 << TRIG_SHIFT) - 1);

    // configuration registers
    logic [15:0]        inv_wheel_radius_reg;
    logic [15:0]        lever_arm_reg;
    logic [GAIN_W-1:0]  inv_mass_reg;
    logic [GAIN_W-1:0]  inv_inertia_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_wheel_radius_reg <= RST_INV_WHEEL_RADIUS;
            lever_arm_reg        <= RST_LEVER_ARM;
            inv_mass_reg         <= RST_INV_MASS;
            inv_inertia_reg      <= RST_INV_INERTIA;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_INV_WHEEL_RADIUS: inv_wheel_radius_reg <= cfg_wdata[15:0];
                REG_LEVER_ARM:        lever_arm_reg        <= cfg_wdata[15:0];
                REG_INV_MASS:         inv_mass_reg         <= cfg_wdata;
                REG_INV_INERTIA:      inv_inertia_reg      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // pipeline advance: everything moves unless the skid register is holding an item
    logic ce;
    logic skid_valid_reg;

    assign ce      = ~skid_valid_reg;
    assign s_ready = ce;

    // ---------------------------------------------------------------
    // input stage: torque sums and quadrant fold of the heading
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0] fl_e, fr_e, bl_e, br_e;
    logic signed [SUM_W-1:0] sx_next, sy_next, st_next;
    logic signed [Z_W-1:0]   z_raw;
    logic signed [Z_W-1:0]   z_next;
    logic                    flip_next;

    assign fl_e = SUM_W'(s_torque_front_left);
    assign fr_e = SUM_W'(s_torque_front_right);
    assign bl_e = SUM_W'(s_torque_back_left);
    assign br_e = SUM_W'(s_torque_back_right);

    assign sy_next = fl_e + fr_e + bl_e + br_e;
    assign sx_next = fr_e + bl_e - fl_e - br_e;
    assign st_next = fl_e - fr_e + bl_e - br_e;

    // heading q3.13 to q30 radians
    assign z_raw = $signed({s_heading, 17'b0});

    // beyond a quarter turn: move by pi toward zero, negate cos and sin later
    always_comb begin
        z_next    = z_raw;
        flip_next = 1'b0;
        if (z_raw > HALF_PI_Q30) begin
            z_next    = z_raw - PI_Q30;
            flip_next = 1'b1;
        end else if (z_raw < -HALF_PI_Q30) begin
            z_next    = z_raw + PI_Q30;
            flip_next = 1'b1;
        end
    end

    logic                    s0_valid_reg;
    logic signed [SUM_W-1:0] s0_sx_reg, s0_sy_reg, s0_st_reg;
    logic signed [Z_W-1:0]   s0_z_reg;
    logic                    s0_flip_reg;
    vel_t                    s0_vel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (ce) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce && s_valid) begin
            s0_sx_reg      <= sx_next;
            s0_sy_reg      <= sy_next;
            s0_st_reg      <= st_next;
            s0_z_reg       <= z_next;
            s0_flip_reg    <= flip_next;
            s0_vel_reg.vx  <= s_vel_x;
            s0_vel_reg.vy  <= s_vel_y;
            s0_vel_reg.wz  <= s_yaw_rate;
        end
    end

    // ---------------------------------------------------------------
    // cordic chain; body forces and lever product ride along as sideband
    // ---------------------------------------------------------------
    rot_t  rot_chain   [CORDIC_STAGES+1];
    side_t side_chain  [CORDIC_STAGES+1];
    logic  valid_chain [CORDIC_STAGES+1];

    assign valid_chain[0]  = s0_valid_reg;
    assign rot_chain[0].x  = CORDIC_GAIN;
    assign rot_chain[0].y  = '0;
    assign rot_chain[0].z  = s0_z_reg;

    // body-frame forces in q16.16, exact
    assign side_chain[0].bfx  = FORCE_W'(s0_sx_reg)
                              * FORCE_W'($signed({1'b0, inv_wheel_radius_reg}));
    assign side_chain[0].bfy  = FORCE_W'(s0_sy_reg)
                              * FORCE_W'($signed({1'b0, inv_wheel_radius_reg}));
    assign side_chain[0].lr   = LR_W'(lever_arm_reg) * LR_W'(inv_wheel_radius_reg);
    assign side_chain[0].st   = s0_st_reg;
    assign side_chain[0].flip = s0_flip_reg;
    assign side_chain[0].vel  = s0_vel_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        mbd_cordic_cell #(
            .STAGE(g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .in_valid (valid_chain[g]),
            .in_rot   (rot_chain[g]),
            .in_side  (side_chain[g]),
            .out_valid(valid_chain[g+1]),
            .out_rot  (rot_chain[g+1]),
            .out_side (side_chain[g+1])
        );
    end

    rot_t  rot_end;
    side_t side_end;

    assign rot_end  = rot_chain[CORDIC_STAGES];
    assign side_end = side_chain[CORDIC_STAGES];

    // valid and velocity shift line alongside the post-chain stages
    logic post_valid_reg [POST_STAGES];
    vel_t post_vel_reg   [POST_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < POST_STAGES; i++) begin
                post_valid_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            post_valid_reg[0] <= valid_chain[CORDIC_STAGES];
            for (int i = 1; i < POST_STAGES; i++) begin
                post_valid_reg[i] <= post_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            post_vel_reg[0] <= side_end.vel;
            for (int i = 1; i < POST_STAGES; i++) begin
                post_vel_reg[i] <= post_vel_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // p1: cos/sin to q16 (toward zero, quadrant flip), lever product
    // ---------------------------------------------------------------
    logic signed [XY_W-1:0]   x_rnd, y_rnd;
    logic signed [XY_W-1:0]   x_q, y_q;
    logic signed [TRIG_W-1:0] cos_t, sin_t;
    logic signed [TRIG_W-1:0] cos_next, sin_next;
    logic signed [PROD_W-1:0] p_next;

    assign x_rnd = rot_end.x + (rot_end.x[XY_W-1] ? TRUNC_BIAS : '0);
    assign y_rnd = rot_end.y + (rot_end.y[XY_W-1] ? TRUNC_BIAS : '0);
    assign x_q   = x_rnd >>> TRIG_SHIFT;
    assign y_q   = y_rnd >>> TRIG_SHIFT;
    assign cos_t = TRIG_W'(x_q);
    assign sin_t = TRIG_W'(y_q);

    assign cos_next = side_end.flip ? -cos_t : cos_t;
    assign sin_next = side_end.flip ? -sin_t : sin_t;
    assign p_next   = PROD_W'(side_end.st) * PROD_W'($signed({1'b0, side_end.lr}));

    logic signed [TRIG_W-1:0]  p1_cos_reg, p1_sin_reg;
    logic signed [PROD_W-1:0]  p1_p_reg;
    logic signed [FORCE_W-1:0] p1_bfx_reg, p1_bfy_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p1_cos_reg <= cos_next;
            p1_sin_reg <= sin_next;
            p1_p_reg   <= p_next;
            p1_bfx_reg <= side_end.bfx;
            p1_bfy_reg <= side_end.bfy;
        end
    end

    // ---------------------------------------------------------------
    // p2: rotation products; yaw torque to sign and magnitude
    // ---------------------------------------------------------------
    logic [PROD_W-1:0] p_abs;

    assign p_abs = p1_p_reg[PROD_W-1] ? PROD_W'(-p1_p_reg) : PROD_W'(p1_p_reg);

    logic signed [WSUM_W-1:0] p2_xc_reg, p2_ys_reg, p2_yc_reg, p2_xs_reg;
    logic                     p2_tz_neg_reg;
    logic [MAG_W-1:0]         p2_tz_mag_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p2_xc_reg     <= WSUM_W'(p1_bfx_reg) * WSUM_W'(p1_cos_reg);
            p2_ys_reg     <= WSUM_W'(p1_bfy_reg) * WSUM_W'(p1_sin_reg);
            p2_yc_reg     <= WSUM_W'(p1_bfy_reg) * WSUM_W'(p1_cos_reg);
            p2_xs_reg     <= WSUM_W'(p1_bfx_reg) * WSUM_W'(p1_sin_reg);
            // yaw torque is the negated product
            p2_tz_neg_reg <= ~p1_p_reg[PROD_W-1];
            p2_tz_mag_reg <= MAG_W'(p_abs >> TZ_SHIFT);
        end
    end

    // ---------------------------------------------------------------
    // p3: world force sums in q16.32
    // ---------------------------------------------------------------
    logic signed [WSUM_W-1:0] p3_wx_reg, p3_wy_reg;
    logic                     p3_tz_neg_reg;
    logic [MAG_W-1:0]         p3_tz_mag_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p3_wx_reg     <= p2_xc_reg - p2_ys_reg;
            p3_wy_reg     <= p2_yc_reg + p2_xs_reg;
            p3_tz_neg_reg <= p2_tz_neg_reg;
            p3_tz_mag_reg <= p2_tz_mag_reg;
        end
    end

    // ---------------------------------------------------------------
    // p4: world forces to sign and q16.16 magnitude
    // ---------------------------------------------------------------
    logic [WSUM_W-1:0] wx_abs, wy_abs;

    assign wx_abs = p3_wx_reg[WSUM_W-1] ? WSUM_W'(-p3_wx_reg) : WSUM_W'(p3_wx_reg);
    assign wy_abs = p3_wy_reg[WSUM_W-1] ? WSUM_W'(-p3_wy_reg) : WSUM_W'(p3_wy_reg);

    logic             p4_wx_neg_reg, p4_wy_neg_reg, p4_tz_neg_reg;
    logic [MAG_W-1:0] p4_wx_mag_reg, p4_wy_mag_reg, p4_tz_mag_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p4_wx_neg_reg <= p3_wx_reg[WSUM_W-1];
            p4_wy_neg_reg <= p3_wy_reg[WSUM_W-1];
            p4_wx_mag_reg <= MAG_W'(wx_abs >> Q_SHIFT);
            p4_wy_mag_reg <= MAG_W'(wy_abs >> Q_SHIFT);
            p4_tz_neg_reg <= p3_tz_neg_reg;
            p4_tz_mag_reg <= p3_tz_mag_reg;
        end
    end

    // ---------------------------------------------------------------
    // inverse mass / inertia scaling with saturation
    // ---------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;

    mbd_scale u_scale_x (
        .aclk   (aclk),
        .ce     (ce),
        .sign_in(p4_wx_neg_reg),
        .mag_in (p4_wx_mag_reg),
        .gain   (inv_mass_reg),
        .acc_out(acc_x)
    );

    mbd_scale u_scale_y (
        .aclk   (aclk),
        .ce     (ce),
        .sign_in(p4_wy_neg_reg),
        .mag_in (p4_wy_mag_reg),
        .gain   (inv_mass_reg),
        .acc_out(acc_y)
    );

    mbd_scale u_scale_z (
        .aclk   (aclk),
        .ce     (ce),
        .sign_in(p4_tz_neg_reg),
        .mag_in (p4_tz_mag_reg),
        .gain   (inv_inertia_reg),
        .acc_out(acc_z)
    );

    // ---------------------------------------------------------------
    // output register plus skid register
    // ---------------------------------------------------------------
    res_t res_in;
    logic incoming;

    assign res_in.vel = post_vel_reg[LAST];
    assign res_in.ax  = acc_x;
    assign res_in.ay  = acc_y;
    assign res_in.az  = acc_z;
    assign incoming   = ce & post_valid_reg[LAST];

    logic m_valid_reg, m_valid_next;
    logic skid_valid_next;
    logic load_out, load_skid, out_from_skid;
    res_t m_res_reg, skid_res_reg;

    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (skid_valid_reg) begin
            // pipeline is frozen; drain the skid item once the output moves
            if (m_ready) begin
                m_valid_next    = 1'b1;
                skid_valid_next = 1'b0;
                load_out        = 1'b1;
                out_from_skid   = 1'b1;
            end
        end else if (incoming) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_next = 1'b1;
                load_out     = 1'b1;
            end else begin
                skid_valid_next = 1'b1;
                load_skid       = 1'b1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_res_reg <= out_from_skid ? skid_res_reg : res_in;
        end
        if (load_skid) begin
            skid_res_reg <= res_in;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_dx        = m_res_reg.vel.vx;
    assign m_dy        = m_res_reg.vel.vy;
    assign m_dheading  = m_res_reg.vel.wz;
    assign m_accel_x   = m_res_reg.ax;
    assign m_accel_y   = m_res_reg.ay;
    assign m_yaw_accel = m_res_reg.az;

endmodule

`default_nettype wire

// ===== src/mbd_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module mbd_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic signed [15:0]  m_dx,
    input wire logic signed [15:0]  m_dy,
    input wire logic signed [15:0]  m_dheading,
    input wire logic signed [31:0]  m_accel_x,
    input wire logic signed [31:0]  m_accel_y,
    input wire logic signed [31:0]  m_yaw_accel
);

    logic [143:0] m_payload;

    assign m_payload = {m_dx, m_dy, m_dheading, m_accel_x, m_accel_y, m_yaw_accel};

    // a result waiting on the output stays put
    `MBD_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped")
    `MBD_ASSERT(a_out_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_payload), "result changed under stall")

    // reset empties the output
    `MBD_ASSERT_ALWAYS(a_rst_out, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // skid register drains as soon as the output moves
    `MBD_ASSERT(a_ready_back, aclk, aresetn, m_ready |=> s_ready, "input stalled after output taken")

    // input only stalls after an output stall
    `MBD_ASSERT(a_ready_cause, aclk, aresetn, !s_ready |-> $past(m_valid && !m_ready), "input stalled without cause")

endmodule

bind mecanum_body_dynamics_derivative mbd_checker u_mbd_checker (.*);

`default_nettype wire
